@@ sv/assert_macros.svh @@
// Assertion macros for the DAWG lookup RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define DAWG_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define DAWG_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define DAWG_ASSERT(lbl, clk, rst, prop, msg)
`define DAWG_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

@@ sv/dawg_pkg.sv @@
// Types, constants and node-word helpers for the DAWG word and hook lookup.
// No dependencies; used by the interfaces and all modules.
package dawg_pkg;

  localparam int ADDR_FIELD_W = 16;
  localparam int WORD_W       = 32;
  localparam int CODE_W       = 6;
  localparam int CHILD_W      = 24;
  localparam int HOOK_W       = 30;

  localparam logic [CODE_W-1:0] NO_LETTER_MIN = 6'd30;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHAIN_CHK,
    S_HOOK_RD,
    S_HOOK_CHK,
    S_OUT
  } state_t;

  typedef struct packed {
    logic                    req_type;
    logic [ADDR_FIELD_W-1:0] node_addr;
    logic [WORD_W-1:0]       node_word;
    logic [CODE_W-1:0]       letter_code;
    logic                    last_letter;
  } req_t;

  typedef struct packed {
    logic                    word_found;
    logic                    prefix_found;
    logic [ADDR_FIELD_W-1:0] end_node;
    logic [HOOK_W-1:0]       hooks;
  } res_t;

  function automatic logic [CODE_W-1:0] word_letter(input logic [WORD_W-1:0] w);
    return w[CODE_W-1:0];
  endfunction

  function automatic logic word_last(input logic [WORD_W-1:0] w);
    return w[6];
  endfunction

  function automatic logic word_eow(input logic [WORD_W-1:0] w);
    return w[7];
  endfunction

  function automatic logic [CHILD_W-1:0] word_child(input logic [WORD_W-1:0] w);
    return w[WORD_W-1:8];
  endfunction

endpackage

@@ sv/dawg_if.sv @@
// Valid/ready channel interfaces for query/load requests and lookup results.
// Depends on dawg_pkg for field widths.
interface dawg_req_if;
  logic                              valid;
  logic                              ready;
  logic                              req_type;
  logic [dawg_pkg::ADDR_FIELD_W-1:0] node_addr;
  logic [dawg_pkg::WORD_W-1:0]       node_word;
  logic [dawg_pkg::CODE_W-1:0]       letter_code;
  logic                              last_letter;

  modport source (output valid, req_type, node_addr, node_word, letter_code, last_letter,
                  input ready);
  modport sink   (input valid, req_type, node_addr, node_word, letter_code, last_letter,
                  output ready);
endinterface

interface dawg_rsp_if;
  logic                              valid;
  logic                              ready;
  logic                              word_found;
  logic                              prefix_found;
  logic [dawg_pkg::ADDR_FIELD_W-1:0] end_node;
  logic [dawg_pkg::HOOK_W-1:0]       hooks;

  modport source (output valid, word_found, prefix_found, end_node, hooks, input ready);
  modport sink   (input valid, word_found, prefix_found, end_node, hooks, output ready);
endinterface

@@ sv/dawg_word_and_hook_lookup.sv @@
// DAWG word and hook lookup. Loads write the node table directly. A query letter after a miss
// does no walk, else it walks a sibling chain (one node word read per cycle, RAM port).
// The final letter's result goes into the output register, and when the end node has a child,
// the children are first scanned for hooks; one item in flight.
// Sync active-high reset clears the walk state and the output valid at once; the node
// table is not cleared, no sweep.
module dawg_word_and_hook_lookup #(
  parameter int ADDR_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  dawg_req_if.sink   req,
  dawg_rsp_if.source rsp
);
  import dawg_pkg::*;

  req_t              in_req;
  res_t              res;
  logic              res_valid;
  logic              slot_free;
  logic              mem_we;
  logic [ADDR_BITS-1:0] mem_waddr;
  logic [ADDR_BITS-1:0] mem_raddr;
  logic [WORD_W-1:0] mem_wdata;
  logic [WORD_W-1:0] mem_rdata;
  logic              out_valid;
  res_t              out_res;

  // Gather the request transaction payload into one bundle.
  assign in_req.req_type    = req.req_type;
  assign in_req.node_addr   = req.node_addr;
  assign in_req.node_word   = req.node_word;
  assign in_req.letter_code = req.letter_code;
  assign in_req.last_letter = req.last_letter;

  // Node table: the walker issues one read a cycle and sees the data on the next cycle.
  dawg_node_mem #(
    .ADDR_BITS (ADDR_BITS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Sequencer: accepts loads and query letters, walks chains, builds the result.
  dawg_walker #(
    .ADDR_BITS (ADDR_BITS)
  ) u_walker (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .in_req    (in_req),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .res_valid (res_valid),
    .res       (res),
    .slot_free (slot_free)
  );

  // Output register: hold a finished result until the sink takes the transaction,
  // while the walker goes on with the next word.
  assign slot_free = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && slot_free) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Advance the payload only when the slot is free.
  always_ff @(posedge clk) begin
    if (res_valid && slot_free) begin
      out_res <= res;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.word_found   = out_res.word_found;
  assign rsp.prefix_found = out_res.prefix_found;
  assign rsp.end_node     = out_res.end_node;
  assign rsp.hooks        = out_res.hooks;

endmodule

@@ sv/dawg_node_mem.sv @@
// Node table: single-port-write, single-port-read synchronous RAM.
// Depends on dawg_pkg for the word width.
module dawg_node_mem #(
  parameter int ADDR_BITS = 16
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [ADDR_BITS-1:0]        waddr,
  input  logic [dawg_pkg::WORD_W-1:0] wdata,
  input  logic [ADDR_BITS-1:0]        raddr,
  output logic [dawg_pkg::WORD_W-1:0] rdata
);
  import dawg_pkg::*;

  logic [WORD_W-1:0] mem [2**ADDR_BITS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ sv/dawg_walker.sv @@
// Lookup sequencer: walks sibling chains and the hook chain through the node table.
// Depends on dawg_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dawg_walker #(
  parameter int ADDR_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  dawg_pkg::req_t              in_req,
  output logic                        mem_we,
  output logic [ADDR_BITS-1:0]        mem_waddr,
  output logic [dawg_pkg::WORD_W-1:0] mem_wdata,
  output logic [ADDR_BITS-1:0]        mem_raddr,
  input  logic [dawg_pkg::WORD_W-1:0] mem_rdata,
  output logic                        res_valid,
  output dawg_pkg::res_t              res,
  input  logic                        slot_free
);
  import dawg_pkg::*;

  state_t state, state_next;

  logic [ADDR_BITS-1:0] cur_idx;
  logic                 miss;
  logic                 first;
  logic [ADDR_BITS-1:0] idx;
  logic [CODE_W-1:0]    code;
  logic                 last;
  res_t                 pend;

  logic                      accept;
  logic                      is_query;
  logic                      match;
  logic                      at_end;
  logic [CHILD_W-1:0]        child_raw;
  logic                      child_zero;
  logic [ADDR_BITS-1:0]      child_idx;
  logic [ADDR_BITS-1:0]      idx_inc;
  logic [ADDR_BITS-1:0]      start_idx;
  logic [ADDR_BITS+15:0]     load_ext;
  logic [ADDR_BITS+15:0]     idx_ext;
  logic                      hook_hit;

  assign accept     = in_valid && in_ready;
  assign is_query   = (in_req.req_type == REQ_QUERY);
  assign match      = (code < NO_LETTER_MIN) && (word_letter(mem_rdata) == code);
  assign at_end     = word_last(mem_rdata) || (idx == {ADDR_BITS{1'b1}});
  assign child_raw  = word_child(mem_rdata);
  assign child_zero = (child_raw == '0);
  assign child_idx  = child_raw[ADDR_BITS-1:0];
  assign idx_inc    = ADDR_BITS'(idx + 1'b1);
  assign start_idx  = first ? '0 : cur_idx;
  assign load_ext   = {{ADDR_BITS{1'b0}}, in_req.node_addr};
  assign idx_ext    = {16'b0, idx};
  assign hook_hit   = word_eow(mem_rdata) && (word_letter(mem_rdata) < NO_LETTER_MIN);

  assign mem_waddr = load_ext[ADDR_BITS-1:0];
  assign mem_wdata = in_req.node_word;
  assign res       = pend;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && is_query) begin
          if (miss) begin
            state_next = in_req.last_letter ? S_OUT : S_IDLE;
          end else begin
            state_next = S_CHAIN_CHK;
          end
        end
      end
      S_CHAIN_CHK: begin
        if (match) begin
          if (!last) begin
            state_next = S_IDLE;
          end else begin
            state_next = child_zero ? S_OUT : S_HOOK_RD;
          end
        end else if (at_end) begin
          state_next = last ? S_OUT : S_IDLE;
        end
      end
      S_HOOK_RD:  state_next = S_HOOK_CHK;
      S_HOOK_CHK: begin
        if (at_end) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs: handshake, memory port, result strobe
  always_comb begin
    in_ready  = 1'b0;
    mem_we    = 1'b0;
    res_valid = 1'b0;
    mem_raddr = idx;
    case (state)
      S_IDLE: begin
        in_ready  = 1'b1;
        mem_we    = in_valid && !is_query;
        mem_raddr = start_idx;
      end
      S_CHAIN_CHK: mem_raddr = idx_inc;
      S_HOOK_RD:   mem_raddr = idx;
      S_HOOK_CHK:  mem_raddr = idx_inc;
      S_OUT:       res_valid = 1'b1;
      default:     mem_raddr = idx;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      cur_idx <= '0;
      miss    <= 1'b0;
      first   <= 1'b1;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          if (accept && is_query) begin
            first <= 1'b0;
            if (first) begin
              cur_idx <= '0;
            end
          end
        end
        S_CHAIN_CHK: begin
          if (match) begin
            if (!last) begin
              if (child_zero) begin
                miss <= 1'b1;
              end else begin
                cur_idx <= child_idx;
              end
            end else begin
              cur_idx <= idx;
            end
          end else if (at_end) begin
            miss <= 1'b1;
          end
        end
        S_OUT: begin
          if (slot_free) begin
            cur_idx <= '0;
            miss    <= 1'b0;
            first   <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Walk datapath: index, letter under search, pending result
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept && is_query) begin
          idx  <= start_idx;
          code <= in_req.letter_code;
          last <= in_req.last_letter;
          if (miss) begin
            pend <= '0;
          end
        end
      end
      S_CHAIN_CHK: begin
        if (match) begin
          if (last) begin
            pend.word_found   <= word_eow(mem_rdata);
            pend.prefix_found <= 1'b1;
            pend.end_node     <= idx_ext[15:0];
            pend.hooks        <= '0;
            idx               <= child_idx;
          end
        end else if (at_end) begin
          pend <= '0;
        end else begin
          idx <= idx_inc;
        end
      end
      S_HOOK_CHK: begin
        if (hook_hit) begin
          pend.hooks <= pend.hooks | (HOOK_W'(1) << word_letter(mem_rdata));
        end
        if (!at_end) begin
          idx <= idx_inc;
        end
      end
      default: begin
      end
    endcase
  end

  `DAWG_ASSERT_NEXT(a_chain_step, clk, rst, state == S_CHAIN_CHK && !match && !at_end, state == S_CHAIN_CHK && idx == ADDR_BITS'($past(idx) + 1'b1), "sibling walk skipped a node")
  `DAWG_ASSERT_NEXT(a_word_end_clear, clk, rst, state == S_OUT && slot_free, cur_idx == '0 && !miss && first, "walk state not cleared at word end")
  `DAWG_ASSERT(a_word_has_prefix, clk, rst, res_valid && res.word_found |-> res.prefix_found, "word found without its prefix")

endmodule

@@ sim/dawg_lookup_checker.sv @@
// Watches the request and result channels of the DAWG word and hook lookup and predicts results.
// Depends on dawg_pkg and the dawg_req_if / dawg_rsp_if interfaces.
`timescale 1ns / 100ps

module dawg_lookup_checker #(
  parameter int ADDR_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  dawg_req_if  req_mon,
  dawg_rsp_if  rsp_mon,
  output int   mismatch_count,
  output int   lookups_waiting
);
  import dawg_pkg::*;

  localparam int unsigned DEPTH    = 1 << ADDR_BITS;
  localparam int unsigned IDX_MASK = DEPTH - 1;
  localparam int          LAST_BIT = 6;
  localparam int          EOW_BIT  = 7;

  // Own copy of the node table and the letter walk.
  logic [WORD_W-1:0] node_mem [DEPTH];
  int unsigned       walk_idx;
  bit                walk_missed;
  bit                word_start;
  res_t              lookups_q [$];
  int                mismatches = 0;

  always @(posedge clk) begin : track
    res_t              want;
    res_t              got;
    logic [WORD_W-1:0] w;
    logic [CHILD_W-1:0] raw;
    int unsigned       idx;
    bit                found;
    bit                done;
    if (rst) begin
      walk_idx    = 0;
      walk_missed = 1'b0;
      word_start  = 1'b1;
      lookups_q.delete();
    end else begin
      if (rsp_mon.valid && rsp_mon.ready) begin
        got.word_found   = rsp_mon.word_found;
        got.prefix_found = rsp_mon.prefix_found;
        got.end_node     = rsp_mon.end_node;
        got.hooks        = rsp_mon.hooks;
        if (lookups_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected lookup result: word=%0b prefix=%0b end=%h hooks=%h",
                     got.word_found, got.prefix_found, got.end_node, got.hooks);
        end else begin
          want = lookups_q.pop_front();
          if (got.word_found !== want.word_found || got.prefix_found !== want.prefix_found ||
              got.end_node !== want.end_node || got.hooks !== want.hooks) begin
            mismatches++;
            if (mismatches <= 10)
              $display("lookup mismatch: exp word=%0b prefix=%0b end=%h hooks=%h, got word=%0b prefix=%0b end=%h hooks=%h",
                       want.word_found, want.prefix_found, want.end_node, want.hooks,
                       got.word_found, got.prefix_found, got.end_node, got.hooks);
          end
        end
      end

      if (req_mon.valid && req_mon.ready) begin
        if (req_mon.req_type == REQ_LOAD) begin
          node_mem[req_mon.node_addr % DEPTH] = req_mon.node_word;
        end else begin
          if (word_start) walk_idx = 0;
          word_start = 1'b0;
          if (!walk_missed) begin
            // Walk the sibling chain; the last table entry always closes it.
            idx   = walk_idx;
            found = 1'b0;
            done  = 1'b0;
            while (!done) begin
              w = node_mem[idx];
              if (req_mon.letter_code < NO_LETTER_MIN && w[CODE_W-1:0] == req_mon.letter_code) begin
                found = 1'b1;
                done  = 1'b1;
              end else if (w[LAST_BIT] || idx == IDX_MASK) begin
                done = 1'b1;
              end else begin
                idx++;
              end
            end
            if (!found) begin
              walk_missed = 1'b1;
            end else if (!req_mon.last_letter) begin
              // Zero test on the full child field, reduction afterwards.
              raw = node_mem[idx][WORD_W-1:8];
              if (raw == '0) walk_missed = 1'b1;
              else walk_idx = raw % DEPTH;
            end else begin
              walk_idx = idx;
            end
          end

          if (req_mon.last_letter) begin
            want = '0;
            if (!walk_missed) begin
              want.word_found   = node_mem[walk_idx][EOW_BIT];
              want.prefix_found = 1'b1;
              want.end_node     = walk_idx[ADDR_FIELD_W-1:0];
              raw = node_mem[walk_idx][WORD_W-1:8];
              if (raw != '0) begin
                idx  = raw % DEPTH;
                done = 1'b0;
                while (!done) begin
                  w = node_mem[idx];
                  if (w[EOW_BIT] && w[CODE_W-1:0] < NO_LETTER_MIN)
                    want.hooks[w[CODE_W-1:0]] = 1'b1;
                  if (w[LAST_BIT] || idx == IDX_MASK) done = 1'b1;
                  else idx++;
                end
              end
            end
            lookups_q.push_back(want);
            walk_idx    = 0;
            walk_missed = 1'b0;
            word_start  = 1'b1;
          end
        end
      end
    end
    mismatch_count  <= mismatches;
    lookups_waiting <= lookups_q.size();
  end

endmodule

@@ sim/tb_top.sv @@
// Top of the DAWG word and hook lookup testbench: clock, reset, stimulus, receiver and verdict.
// Depends on dawg_pkg, the channel interfaces, the lookup block and dawg_lookup_checker.
`timescale 1ns / 100ps

module tb_top;
  import dawg_pkg::*;

  localparam int ADDR_BITS         = 16;
  localparam int unsigned DEPTH    = 1 << ADDR_BITS;
  localparam int WATCHDOG_LIMIT    = 4000;
  localparam int HOLDOFF_CYCLES    = 300;
  localparam int PHASES            = 4;
  localparam int ITEMS_PER_PHASE   = 240;
  localparam int DRAIN_CYCLES      = 100;

  // Letter codes used by the directed part.
  localparam logic [CODE_W-1:0] CODE_A      = 6'd0;
  localparam logic [CODE_W-1:0] CODE_F      = 6'd5;
  localparam logic [CODE_W-1:0] CODE_H      = 6'd7;
  localparam logic [CODE_W-1:0] CODE_Z      = 6'd25;
  localparam logic [CODE_W-1:0] CODE_NTILDE = 6'd29;
  localparam logic [CODE_W-1:0] CODE_TOP    = 6'd63;

  logic clk;
  logic rst;

  dawg_req_if req_ch ();
  dawg_rsp_if rsp_ch ();

  int mismatch_count;
  int lookups_waiting;
  bit holdoff_go;

  // Stimulus-side image of the table, used only to steer queries along real paths.
  logic [WORD_W-1:0] shadow [DEPTH];
  int unsigned       chain_start [$];
  int unsigned       chain_len [$];
  int unsigned       len_at [int unsigned];
  int                burst_left;
  int                items_sent;

  dawg_word_and_hook_lookup #(
    .ADDR_BITS(ADDR_BITS)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  dawg_lookup_checker #(
    .ADDR_BITS(ADDR_BITS)
  ) u_checker (
    .clk            (clk),
    .rst            (rst),
    .req_mon        (req_ch),
    .rsp_mon        (rsp_ch),
    .mismatch_count (mismatch_count),
    .lookups_waiting(lookups_waiting)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [WORD_W-1:0] pack_node(input logic [CODE_W-1:0] code,
                                                  input logic last, input logic eow,
                                                  input logic [CHILD_W-1:0] child);
    return {child, eow, last, code};
  endfunction

  // Random node for position pos of a chain. Only the final node closes a chain, except
  // for the chain that runs into the table end, which relies on the end to stop the walk.
  // Children always point at a chain start of the current table, root included.
  function automatic logic [WORD_W-1:0] random_node(input int unsigned chain,
                                                    input int unsigned pos);
    logic [CODE_W-1:0]  code;
    logic               last;
    logic [CHILD_W-1:0] child;
    int unsigned        target;
    code = ($urandom_range(0, 9) == 0) ? CODE_W'($urandom_range(30, 63))
                                       : CODE_W'($urandom_range(0, 29));
    last = (pos == chain_len[chain] - 1) &&
           (chain_start[chain] + chain_len[chain] != DEPTH);
    if ($urandom_range(0, 2) == 0) begin
      child = '0;
    end else begin
      target = chain_start[$urandom_range(0, chain_start.size() - 1)];
      // Upper child bits are noise; with a root target they can make a non-zero child
      // that reduces to index zero.
      child = {8'($urandom_range(0, 255)), 16'(target)};
    end
    return pack_node(code, last, 1'($urandom_range(0, 1)), child);
  endfunction

  // Offer one transaction and hold it until accepted. Bursts of random length
  // are separated by random gaps with valid low.
  task automatic push(input logic rt, input logic [ADDR_FIELD_W-1:0] addr,
                      input logic [WORD_W-1:0] word, input logic [CODE_W-1:0] code,
                      input logic last);
    if (burst_left == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
    end
    burst_left--;
    req_ch.valid       <= 1'b1;
    req_ch.req_type    <= rt;
    req_ch.node_addr   <= addr;
    req_ch.node_word   <= word;
    req_ch.letter_code <= code;
    req_ch.last_letter <= last;
    do @(posedge clk); while (!req_ch.ready);
    items_sent++;
  endtask

  // Unused fields of a transaction carry noise so every bit toggles.
  task automatic send_load(input logic [ADDR_FIELD_W-1:0] addr, input logic [WORD_W-1:0] word);
    shadow[addr % DEPTH] = word;
    push(REQ_LOAD, addr, word, CODE_W'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
  endtask

  task automatic send_letter(input logic [CODE_W-1:0] code, input logic last);
    push(REQ_QUERY, ADDR_FIELD_W'($urandom), WORD_W'($urandom), code, last);
  endtask

  // Drop valid and hold the sender until every expected result has come back.
  task automatic drain();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (lookups_waiting != 0);
  endtask

  // Lay out a fresh set of chains: root at 0, a few spread over the address space,
  // one that ends at the last table entry. Every reachable entry gets written.
  task automatic build_table();
    int unsigned n;
    int unsigned start;
    int unsigned len;
    chain_start.delete();
    chain_len.delete();
    len_at.delete();
    n = $urandom_range(3, 13);
    for (int unsigned i = 0; i <= n; i++) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(16, 30) : $urandom_range(1, 6);
      if (i == 0) begin
        start = 0;
      end else if (i == n) begin
        len   = $urandom_range(1, 4);
        start = DEPTH - len;
      end else begin
        start = i * 4096 + $urandom_range(0, 4096 - 64);
      end
      chain_start.push_back(start);
      chain_len.push_back(len);
      len_at[start] = len;
    end
    for (int unsigned c = 0; c < chain_start.size(); c++)
      for (int unsigned p = 0; p < chain_len[c]; p++)
        send_load(ADDR_FIELD_W'(chain_start[c] + p), random_node(c, p));
  endtask

  // One query word. Well-formed words follow letters that exist on the current chain;
  // each letter may still be swapped for noise, which breaks the word from there on.
  task automatic send_word(input bit well_formed);
    int unsigned        at;
    int unsigned        node;
    int unsigned        n_letters;
    logic [CODE_W-1:0]  code;
    logic [CHILD_W-1:0] raw;
    bit                 on_path;
    n_letters = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 5);
    at        = 0;
    on_path   = well_formed;
    for (int unsigned k = 0; k < n_letters; k++) begin
      if (on_path && $urandom_range(0, 15) != 0) begin
        node = at + $urandom_range(0, len_at[at] - 1);
        code = shadow[node][CODE_W-1:0];
        raw  = shadow[node][WORD_W-1:8];
        if (raw == '0) on_path = 1'b0;
        else at = raw % DEPTH;
      end else begin
        code    = CODE_W'($urandom_range(0, 63));
        on_path = 1'b0;
      end
      send_letter(code, k == n_letters - 1);
    end
  endtask

  // Receiver: segments of steady, sparse or bursty ready, and once a long hold-off
  // while the sender keeps offering, so the block backs up into its input.
  initial begin : result_sink
    int seg;
    int mode;
    bit hold_done;
    rsp_ch.ready <= 1'b0;
    hold_done = 1'b0;
    forever begin
      if (holdoff_go && !hold_done) begin
        hold_done = 1'b1;
        repeat (HOLDOFF_CYCLES) begin
          @(posedge clk);
          rsp_ch.ready <= 1'b0;
        end
      end else begin
        seg  = $urandom_range(10, 120);
        mode = $urandom_range(0, 3);
        for (int k = 0; k < seg; k++) begin
          @(posedge clk);
          case (mode)
            0: rsp_ch.ready <= 1'b1;
            1: rsp_ch.ready <= ($urandom_range(0, 2) != 0);
            2: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ch.ready <= (k >= 15);
          endcase
        end
      end
    end
  end

  // Watchdog: end the run when no transaction moves on either channel for too long.
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) idle = 0;
      else idle++;
    end
    $display("tb_top failed");
    $finish;
  end

  initial begin : stimulus
    int target;
    int pick;
    int unsigned c;
    int unsigned p;
    rst                <= 1'b1;
    holdoff_go         <= 1'b0;
    req_ch.valid       <= 1'b0;
    req_ch.req_type    <= REQ_LOAD;
    req_ch.node_addr   <= '0;
    req_ch.node_word   <= '0;
    req_ch.letter_code <= '0;
    req_ch.last_letter <= 1'b0;
    burst_left = 0;
    items_sent = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed table: root chain, a chain at 16 whose last node points back to the root
    // through a child that is non-zero but reduces to zero, and a chain at the table end
    // with no closing sibling bit.
    send_load(16'h0000, pack_node(CODE_A, 1'b0, 1'b1, 24'h000010));
    send_load(16'h0001, pack_node(CODE_NTILDE, 1'b0, 1'b0, 24'hFFFFFE));
    send_load(16'h0002, pack_node(NO_LETTER_MIN, 1'b1, 1'b1, 24'h000000));
    send_load(16'h0010, pack_node(CODE_Z, 1'b0, 1'b1, 24'h000000));
    send_load(16'h0011, pack_node(CODE_A, 1'b1, 1'b1, 24'h010000));
    send_load(16'hFFFE, pack_node(CODE_F, 1'b0, 1'b1, 24'h000010));
    send_load(16'hFFFF, pack_node(CODE_TOP, 1'b0, 1'b1, 24'h000000));

    // Single-letter words, hooks from both child chains.
    send_letter(CODE_A, 1'b1);
    send_letter(CODE_NTILDE, 1'b1);
    // Descend into the chain at the table end, hit and miss there.
    send_letter(CODE_NTILDE, 1'b0);
    send_letter(CODE_F, 1'b1);
    send_letter(CODE_NTILDE, 1'b0);
    send_letter(CODE_H, 1'b1);
    // Wrap back to the root through the reduced child index.
    send_letter(CODE_A, 1'b0);
    send_letter(CODE_A, 1'b0);
    send_letter(CODE_A, 1'b1);
    // Missing child mid-word, then letters that must do no walk.
    send_letter(CODE_A, 1'b0);
    send_letter(CODE_Z, 1'b0);
    send_letter(CODE_A, 1'b0);
    send_letter(CODE_A, 1'b1);
    // Codes that are no letter never match, even on a node that carries them.
    send_letter(NO_LETTER_MIN, 1'b1);
    send_letter(CODE_TOP, 1'b1);
    // Rewrite a node between the letters of one word.
    send_letter(CODE_A, 1'b0);
    send_load(16'h0010, pack_node(CODE_Z, 1'b0, 1'b0, 24'h000000));
    send_letter(CODE_Z, 1'b1);
    drain();

    for (int phase = 0; phase < PHASES; phase++) begin
      build_table();
      if (phase == 1) holdoff_go <= 1'b1;
      target = items_sent + ITEMS_PER_PHASE;
      while (items_sent < target) begin
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
          // Rewrite one node of the current layout; structure stays walkable.
          c = $urandom_range(0, chain_start.size() - 1);
          p = $urandom_range(0, chain_len[c] - 1);
          send_load(ADDR_FIELD_W'(chain_start[c] + p), random_node(c, p));
        end else begin
          send_word(pick < 85);
        end
      end
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && lookups_waiting == 0)
      $display("tb_top passed");
    else
      $display("tb_top failed");
    $finish;
  end

endmodule
